@@ hdl/ece_pkg.sv @@
// Shared constants, register indexes, status codes and control structs
// for the entropy credit estimator. No dependencies.
`default_nettype none

package ece_pkg;

    localparam int SOURCE_COUNT_DEF   = 8;
    localparam int DISCOUNTED_TOP_DEF = 1;

    localparam int CREDIT_W   = 7;
    localparam int CREDIT_CAP = 70;
    localparam int LEVEL_W    = 11;
    localparam int LEVEL_MIN  = -1024;
    localparam int LEVEL_MAX  = 1023;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int ACTIVE_W    = 4;
    localparam int THRESH_W    = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_SOURCES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEYED_MODE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_READY_THRESHOLD = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd64;

    localparam logic [1:0] STATUS_ACCEPTED   = 2'd0;
    localparam logic [1:0] STATUS_BAD_SOURCE = 2'd1;
    localparam logic [1:0] STATUS_STARTUP    = 2'd2;

    typedef struct packed {
        logic [ACTIVE_W-1:0] active_sources;
        logic                keyed_mode;
        logic [THRESH_W-1:0] ready_threshold;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture input beat
        logic reject;  // stage a bad-source / startup result
        logic update;  // add estimate to credit, clear accumulators
        logic step;    // one credit of the scan
        logic calc;    // form saturated level
        logic decide;  // threshold compare, stage result, clear on fire
        logic emit;    // staged result to output registers
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic reject;
        logic scan_last;
    } sts_t;

endpackage

`default_nettype wire

@@ hdl/ece_ctrl.sv @@
// Sequencing state machine for the entropy credit estimator.
// Depends on ece_pkg for the command and status structs.
`default_nettype none

module ece_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ece_pkg::cmd_t      cmd,
    input  wire ece_pkg::sts_t sts
);
    import ece_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_CALC,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.reject)
                begin
                    cmd.reject = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_last)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ece_dp.sv @@
// Datapath: credit store, scan accumulators, top-credit list, level and
// result registers. Depends on ece_pkg; driven by ece_ctrl commands.
`default_nettype none

module ece_dp #(
    parameter int SOURCE_COUNT   = ece_pkg::SOURCE_COUNT_DEF,
    parameter int DISCOUNTED_TOP = ece_pkg::DISCOUNTED_TOP_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ece_pkg::cmd_t                cmd,
    output ece_pkg::sts_t                     sts,
    input  wire ece_pkg::cfg_t                cfg,
    input  wire logic [7:0]                   source_index,
    input  wire logic [7:0]                   estimate,
    output logic [1:0]                        status,
    output logic                              fire,
    output logic signed [ece_pkg::LEVEL_W-1:0] level
);
    import ece_pkg::*;

    localparam int IDX_W    = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
    localparam int CMP_W    = (IDX_W > ACTIVE_W) ? IDX_W : ACTIVE_W;
    localparam int SUM_W    = $clog2(SOURCE_COUNT * CREDIT_CAP + 1);
    localparam int TOP_N    = (DISCOUNTED_TOP > 0) ? DISCOUNTED_TOP : 1;
    localparam int TOP_W    = $clog2(TOP_N * CREDIT_CAP + 1);
    localparam int WIDE_A   = (SUM_W > TOP_W) ? SUM_W : TOP_W;
    localparam int DIFF_W   = ((WIDE_A > LEVEL_W) ? WIDE_A : LEVEL_W) + 1;

    logic [CREDIT_W-1:0] credits_reg [SOURCE_COUNT];
    logic [7:0]          src_reg;
    logic [7:0]          est_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic [TOP_W-1:0]    top_total;

    logic [IDX_W-1:0]    rd_idx;
    logic [CREDIT_W-1:0] rd;
    logic [8:0]          raised;
    logic [CREDIT_W-1:0] capped;
    logic                in_active;
    logic                bad_src;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [LEVEL_W-1:0] level_sat;
    logic signed [LEVEL_W-1:0] level_reg;
    logic signed [LEVEL_W:0]   thresh_ext;
    logic                      over;

    logic [1:0]                res_status_reg;
    logic                      res_fire_reg;
    logic signed [LEVEL_W-1:0] res_level_reg;
    logic [1:0]                out_status_reg;
    logic                      out_fire_reg;
    logic signed [LEVEL_W-1:0] out_level_reg;

    assign bad_src    = ({1'b0, src_reg} >= 9'(SOURCE_COUNT));
    assign sts.reject = bad_src || !cfg.keyed_mode;
    assign sts.scan_last = (cnt_reg == IDX_W'(SOURCE_COUNT - 1));

    // single read port: source entry during update, scan counter otherwise
    assign rd_idx = cmd.update ? src_reg[IDX_W-1:0] : cnt_reg;
    assign rd     = credits_reg[rd_idx];

    assign raised = {2'b00, rd} + {1'b0, est_reg};
    assign capped = (raised > 9'(CREDIT_CAP)) ? CREDIT_W'(CREDIT_CAP) : raised[CREDIT_W-1:0];

    assign in_active = (CMP_W'(cnt_reg) < CMP_W'(cfg.active_sources));

    // running sum of the DISCOUNTED_TOP largest credits seen in the scan
    generate
        if (DISCOUNTED_TOP > 0)
        begin : g_top
            logic [CREDIT_W-1:0] top_reg [TOP_N];
            logic [CREDIT_W-1:0] top_next [TOP_N];
            logic [TOP_N-1:0]    greater;
            logic [TOP_W-1:0]    top_sum_reg;

            always_comb
            begin
                for (int j = 0; j < TOP_N; j++)
                    greater[j] = (rd > top_reg[j]);
                for (int j = 0; j < TOP_N; j++)
                begin
                    if (!greater[j])
                        top_next[j] = top_reg[j];
                    else if (j == 0)
                        top_next[j] = rd;
                    else if (greater[j-1])
                        top_next[j] = top_reg[j-1];
                    else
                        top_next[j] = rd;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    for (int j = 0; j < TOP_N; j++)
                        top_reg[j] <= '0;
                    top_sum_reg <= '0;
                end
                else if (cmd.update)
                begin
                    for (int j = 0; j < TOP_N; j++)
                        top_reg[j] <= '0;
                    top_sum_reg <= '0;
                end
                else if (cmd.step)
                begin
                    for (int j = 0; j < TOP_N; j++)
                        top_reg[j] <= top_next[j];
                    if (greater[TOP_N-1])
                        top_sum_reg <= top_sum_reg + TOP_W'(rd - top_reg[TOP_N-1]);
                end
            end

            assign top_total = top_sum_reg;
        end
        else
        begin : g_no_top
            assign top_total = '0;
        end
    endgenerate

    assign diff = $signed({{(DIFF_W-SUM_W){1'b0}}, acc_reg})
                - $signed({{(DIFF_W-TOP_W){1'b0}}, top_total});

    always_comb
    begin
        if (diff > DIFF_W'(LEVEL_MAX))
            level_sat = LEVEL_W'(LEVEL_MAX);
        else if (diff < DIFF_W'(LEVEL_MIN))
            level_sat = LEVEL_W'(LEVEL_MIN);
        else
            level_sat = diff[LEVEL_W-1:0];
    end

    assign thresh_ext = $signed({{(LEVEL_W+1-THRESH_W){1'b0}}, cfg.ready_threshold});
    assign over       = ($signed({level_reg[LEVEL_W-1], level_reg}) > thresh_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SOURCE_COUNT; i++)
                credits_reg[i] <= '0;
        end
        else if (cmd.update)
        begin
            credits_reg[src_reg[IDX_W-1:0]] <= capped;
        end
        else if (cmd.decide && over)
        begin
            for (int i = 0; i < SOURCE_COUNT; i++)
                credits_reg[i] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.update)
        begin
            cnt_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (in_active)
                acc_reg <= acc_reg + SUM_W'(rd);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg <= source_index;
            est_reg <= estimate;
        end
        if (cmd.calc)
            level_reg <= level_sat;
        if (cmd.reject)
        begin
            res_status_reg <= bad_src ? STATUS_BAD_SOURCE : STATUS_STARTUP;
            res_fire_reg   <= 1'b0;
            res_level_reg  <= '0;
        end
        else if (cmd.decide)
        begin
            res_status_reg <= STATUS_ACCEPTED;
            res_fire_reg   <= over;
            res_level_reg  <= level_reg;
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_fire_reg   <= res_fire_reg;
            out_level_reg  <= res_level_reg;
        end
    end

    assign status = out_status_reg;
    assign fire   = out_fire_reg;
    assign level  = out_level_reg;

endmodule

`default_nettype wire

@@ hdl/entropy_credit_estimator_unit.sv @@
// Top level of the entropy credit estimator: configuration registers and
// the controller / datapath pair. Depends on ece_pkg, ece_ctrl, ece_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries source_index and estimate.
//   Output channel (out_valid/out_ready) returns one result per input beat:
//   status, fire and the signed level.
//   Config channel (cfg_valid/cfg_ready) writes register cfg_index with
//   cfg_data: 0 active_sources, 1 keyed_mode, 2 ready_threshold. Other
//   indexes are ignored. cfg_ready is always high; write only while idle.
// Sequence:
//   A rejected beat (bad source or unkeyed) goes from check straight to
//   emit. A credited beat runs check, scan, calc, decide and emit; the
//   scan reads one credit per cycle to form the active sum and the
//   running sum of the largest credits. One item is in flight at a time;
//   in_ready rises again once the result is registered, so a new beat is
//   taken only after the last one has been emitted.
// Reset: all credits zero, active_sources 0, keyed_mode 0, threshold 64.
// Stall: a held result stays on the output registers; the next beat may be
//   accepted and processed, and waits before emit until the output is free.
`default_nettype none

module entropy_credit_estimator_unit #(
    parameter int SOURCE_COUNT   = ece_pkg::SOURCE_COUNT_DEF,
    parameter int DISCOUNTED_TOP = ece_pkg::DISCOUNTED_TOP_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          source_index,
    input  wire logic [7:0]                          estimate,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               status,
    output logic                                     fire,
    output logic signed [ece_pkg::LEVEL_W-1:0]       level,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ece_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [ece_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ece_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_sources  <= '0;
            cfg_reg.keyed_mode      <= 1'b0;
            cfg_reg.ready_threshold <= THRESH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ACTIVE_SOURCES:  cfg_reg.active_sources  <= cfg_data[ACTIVE_W-1:0];
                CFG_KEYED_MODE:      cfg_reg.keyed_mode      <= cfg_data[0];
                CFG_READY_THRESHOLD: cfg_reg.ready_threshold <= cfg_data[THRESH_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    ece_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ece_dp #(
        .SOURCE_COUNT   (SOURCE_COUNT),
        .DISCOUNTED_TOP (DISCOUNTED_TOP)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg          (cfg_reg),
        .source_index (source_index),
        .estimate     (estimate),
        .status       (status),
        .fire         (fire),
        .level        (level)
    );

endmodule

`default_nettype wire

@@ test/tb_entropy_credit_estimator_unit.sv @@
// Self-checking testbench for entropy_credit_estimator_unit: a local credit
// model predicts status, fire and level for every input beat.
// Depends on ece_pkg and the RTL top level only.
`default_nettype none

module tb_entropy_credit_estimator_unit;
    import ece_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SRC_N        = SOURCE_COUNT_DEF;
    localparam int SRC_IDX_W    = $clog2(SRC_N);
    localparam int TOP_N        = DISCOUNTED_TOP_DEF;
    localparam int SETTLE_CYC   = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] src;
        logic [7:0] est;
    } entropy_beat_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic                        fire;
        logic signed [LEVEL_W-1:0]   level;
    } credit_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [7:0]                    source_index = '0;
    logic [7:0]                    estimate = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [1:0]                    status;
    logic                          fire;
    logic signed [LEVEL_W-1:0]     level;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    // local copy of the block's state
    logic [CREDIT_W-1:0]           credit_bank [SRC_N];
    logic [ACTIVE_W-1:0]           active_reg;
    logic                          keyed_reg;
    logic [THRESH_W-1:0]           thresh_reg;

    entropy_beat_t                 beat_queue [$];
    credit_result_t                result_queue [$];

    int  beats_queued  = 0;
    int  beats_taken   = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  fires_seen    = 0;
    int  status_seen [3] = '{0, 0, 0};
    int  cycle_count   = 0;
    bit  steady_run    = 1'b0;
    bit  long_hold_req = 1'b0;

    entropy_credit_estimator_unit #(
        .SOURCE_COUNT   (SRC_N),
        .DISCOUNTED_TOP (TOP_N)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_index (source_index),
        .estimate     (estimate),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .fire         (fire),
        .level        (level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Mostly short idles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Credit one beat and work out the level the block should report.
    function automatic credit_result_t credit_and_rank(input entropy_beat_t b);
        credit_result_t      r;
        logic [CREDIT_W-1:0] ranked [SRC_N];
        logic [CREDIT_W-1:0] t;
        int                  n_act;
        int                  n_top;
        int                  total;
        int                  sum;

        r.status = STATUS_ACCEPTED;
        r.fire   = 1'b0;
        r.level  = '0;
        if (int'(b.src) >= SRC_N) begin
            r.status = STATUS_BAD_SOURCE;
            return r;
        end
        if (!keyed_reg) begin
            r.status = STATUS_STARTUP;
            return r;
        end

        sum = int'(credit_bank[b.src[SRC_IDX_W-1:0]]) + int'(b.est);
        if (sum > CREDIT_CAP)
            sum = CREDIT_CAP;
        credit_bank[b.src[SRC_IDX_W-1:0]] = CREDIT_W'(sum);

        n_act = (int'(active_reg) > SRC_N) ? SRC_N : int'(active_reg);
        n_top = (TOP_N > SRC_N) ? SRC_N : TOP_N;

        ranked = credit_bank;
        for (int i = 0; i < SRC_N - 1; i++)
            for (int j = 0; j < SRC_N - 1 - i; j++)
                if (ranked[j] < ranked[j+1]) begin
                    t           = ranked[j];
                    ranked[j]   = ranked[j+1];
                    ranked[j+1] = t;
                end

        total = 0;
        for (int i = 0; i < n_act; i++)
            total += int'(credit_bank[i]);
        for (int i = 0; i < n_top; i++)
            total -= int'(ranked[i]);
        if (total < LEVEL_MIN)
            total = LEVEL_MIN;
        if (total > LEVEL_MAX)
            total = LEVEL_MAX;

        if (total > int'(thresh_reg)) begin
            r.fire = 1'b1;
            for (int i = 0; i < SRC_N; i++)
                credit_bank[i] = '0;
        end
        r.level = LEVEL_W'(total);
        return r;
    endfunction

    // Sender: one beat at a time from beat_queue, random gaps between beats.
    always @(posedge clk)
    begin
        int gap_left;
        if (!rst_n) begin
            gap_left = 0;
            in_valid <= 1'b0;
        end else if (!(in_valid && !in_ready)) begin
            if (in_valid) begin
                result_queue.push_back(credit_and_rank({source_index, estimate}));
                beats_taken++;
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (beat_queue.size() != 0) begin
                entropy_beat_t b;
                b = beat_queue.pop_front();
                source_index <= b.src;
                estimate     <= b.est;
                in_valid     <= 1'b1;
                gap_left = (!steady_run && $urandom_range(0, 1)) ? idle_len() : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result beat, stalls at random.
    always @(posedge clk)
    begin
        int             stall_left;
        credit_result_t exp_r;
        if (!rst_n) begin
            stall_left = 0;
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (fire)
                    fires_seen++;
                if (status < 3)
                    status_seen[status]++;
                if (result_queue.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected (status %0d)",
                             $realtime, status);
                end else begin
                    exp_r = result_queue.pop_front();
                    if (status !== exp_r.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, exp_r.status, status);
                    end
                    if (fire !== exp_r.fire) begin
                        mismatches++;
                        $display("%0t: fire expected %0d actual %0d",
                                 $realtime, exp_r.fire, fire);
                    end
                    if (level !== exp_r.level) begin
                        mismatches++;
                        $display("%0t: level expected %0d actual %0d",
                                 $realtime, exp_r.level, level);
                    end
                end
            end

            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!steady_run && $urandom_range(0, 99) < 20) begin
                stall_left = idle_len() - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("entropy_credit_estimator_unit verification failed");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ACTIVE_SOURCES:  active_reg = val[ACTIVE_W-1:0];
            CFG_KEYED_MODE:      keyed_reg  = val[0];
            CFG_READY_THRESHOLD: thresh_reg = val[THRESH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(input int act, input int keyed, input int thr);
        write_reg(CFG_ACTIVE_SOURCES,
                  {CFG_DATA_W'($urandom()) & ~CFG_DATA_W'(4'hf)} | CFG_DATA_W'(act));
        write_reg(CFG_KEYED_MODE,
                  {CFG_DATA_W'($urandom()) & ~CFG_DATA_W'(1)} | CFG_DATA_W'(keyed));
        write_reg(CFG_READY_THRESHOLD, CFG_DATA_W'(thr));
    endtask

    task automatic offer(input int src, input int est);
        beat_queue.push_back({8'(src), 8'(est)});
        beats_queued++;
    endtask

    // Wait until every queued beat is taken and answered, then let it settle.
    task automatic wait_idle();
        while (beats_taken != beats_queued || results_seen != beats_taken)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    initial
    begin
        entropy_beat_t b;
        int            pick;
        int            n_beats;

        for (int i = 0; i < SRC_N; i++)
            credit_bank[i] = '0;
        active_reg = '0;
        keyed_reg  = 1'b0;
        thresh_reg = THRESH_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: unkeyed, so only startup routing and bad sources
        offer(0, 255);
        offer(SRC_N - 1, 0);
        offer(SRC_N, 1);
        offer(255, 255);
        wait_idle();

        // keyed, all sources summed, threshold out of reach
        set_mode(SRC_N, 1, 1023);
        offer(0, 255);
        offer(1, 70);
        offer(2, 69);
        offer(SRC_N - 1, 0);
        offer(3, 1);
        offer(1, 5);
        offer(9, 9);
        offer(128, 0);
        wait_idle();

        // nothing summed: level goes negative, never fires at threshold 0; then all sources summed again
        set_mode(0, 1, 0);
        offer(4, 10);
        wait_idle();
        write_reg(CFG_ACTIVE_SOURCES, CFG_DATA_W'(SRC_N));
        offer(5, 1);
        offer(5, 0);
        offer(6, 1);
        offer(2, 3);
        wait_idle();

        // active count beyond the source count sums every credit
        set_mode(15, 1, 64);
        offer(0, 70);
        offer(1, 70);
        offer(2, 0);
        wait_idle();
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
        offer(3, 2);
        wait_idle();

        for (int ph = 0; ph < 9; ph++) begin
            pick = $urandom_range(0, 99);
            set_mode(ph == 0 ? SRC_N :
                     (pick < 70 ? $urandom_range(1, SRC_N) : $urandom_range(0, 15)),
                     ph == 6 ? 0 : 1,
                     ph == 2 ? 0 : (ph == 7 ? 1023 :
                     (pick < 85 ? $urandom_range(0, 250) : $urandom_range(0, 1023))));
            steady_run = (ph == 3 || ph == 4);
            if (ph == 4)
                long_hold_req = 1'b1;
            n_beats = (ph == 6) ? 20 : 75;
            for (int k = 0; k < n_beats; k++) begin
                b.src = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, SRC_N - 1))
                                                      : 8'($urandom_range(SRC_N, 255));
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    b.est = 8'd0;
                else if (pick < 20)
                    b.est = 8'hff;
                else if (pick < 65)
                    b.est = 8'($urandom_range(1, 40));
                else
                    b.est = 8'($urandom());
                offer(int'(b.src), int'(b.est));
            end
            wait_idle();
            steady_run = 1'b0;
        end

        if (result_queue.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived", $realtime, result_queue.size());
        end

        $display("%0d beats checked over several register settings: %0d credited, %0d bad",
                 results_seen, status_seen[STATUS_ACCEPTED], status_seen[STATUS_BAD_SOURCE]);
        $display("source, %0d startup-routed, %0d fires; %0d mismatches",
                 status_seen[STATUS_STARTUP], fires_seen, mismatches);
        if (mismatches == 0)
            $display("entropy_credit_estimator_unit verification clean");
        else
            $display("entropy_credit_estimator_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
